[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/iirl_pkg.sv]
// ----------------------------------------------------------------------------
// iirl_pkg
// Types and constants shared by the indexed insert/remove list.
// ----------------------------------------------------------------------------
package iirl_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 8;
  localparam int unsigned CNT_W = 7;
  // index width inside the cell row, covers the largest supported depth
  localparam int unsigned AT_W  = 11;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NEGATIVE = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [AT_W-1:0] at;
  } cell_ctrl_t;

endpackage

[rtl/core/iirl_if.sv]
// ----------------------------------------------------------------------------
// iirl_req_if / iirl_rsp_if
// Valid/ready channels for list requests and results.
// ----------------------------------------------------------------------------
interface iirl_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  position;
  logic [31:0] value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface iirl_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  entry_count;
  logic [31:0] removed_value;

  modport source (output valid, output status, output entry_count, output removed_value,
                  input ready);
  modport sink   (input valid, input status, input entry_count, input removed_value,
                  output ready);
endinterface

[rtl/core/indexed_insert_remove_list.sv]
// ----------------------------------------------------------------------------
// indexed_insert_remove_list
// Bounded ordered list of signed words edited by position.
// ----------------------------------------------------------------------------
// Channels: req (opcode, position, value) and rsp (status, entry_count,
// removed_value), both valid/ready; a word moves when valid and ready are high.
// Insert puts value at min(position, count); remove takes the entry at
// min(position, count-1). A negative position, a remove from an empty list
// and an insert into a full list leave the list as is and report a status.
// The cell row updates in the cycle the request is accepted; the removed
// word is gathered by a registered radix-4 OR tree of ceil(log4(DEPTH))+1
// stages and registered once more for the result port. One request is in
// flight at a time: req.ready returns the cycle after the result is taken.
// A stalled receiver holds the result and keeps req.ready low.
// Reset empties the list at once; cell contents need no clearing.
// entry_count is 7 bits wide, so DEPTH is used up to 127.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list import iirl_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  iirl_req_if.sink     req,
  iirl_rsp_if.source   rsp
);

  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned TREE_LV = ($clog2(DEPTH) + 1) / 2;

  logic [CW-1:0]    fill_count;
  logic [CW-1:0]    fill_count_next;
  logic             busy;
  logic [TREE_LV:0] pipe;
  logic             out_valid;
  status_t          status_q;
  status_t          status_next;
  logic [CW-1:0]    count_q;
  logic [VAL_W-1:0] removed_q;

  logic             accept;
  logic [AT_W-1:0]  pos_ext;
  logic [AT_W-1:0]  cnt_ext;
  logic [AT_W-1:0]  last_ext;
  cell_ctrl_t       ctrl;

  logic [VAL_W-1:0] cells [DEPTH];
  logic [VAL_W-1:0] taps  [DEPTH];
  logic [VAL_W-1:0] tree_out;

  assign accept   = req.valid && req.ready;
  assign pos_ext  = AT_W'(req.position[POS_W-2:0]);
  assign cnt_ext  = AT_W'(fill_count);
  assign last_ext = cnt_ext - AT_W'(1);

  always_comb begin
    ctrl            = '0;
    status_next     = ST_DONE;
    fill_count_next = fill_count;
    priority if (req.position[POS_W-1]) begin
      status_next = ST_NEGATIVE;
    end else if (req.opcode == OP_INSERT) begin
      if (fill_count == CW'(DEPTH)) begin
        status_next = ST_FULL;
      end else begin
        ctrl.ins        = accept;
        ctrl.at         = (pos_ext < cnt_ext) ? pos_ext : cnt_ext;
        fill_count_next = fill_count + CW'(1);
      end
    end else begin
      if (fill_count == '0) begin
        status_next = ST_EMPTY;
      end else begin
        ctrl.rem        = accept;
        ctrl.at         = (pos_ext < last_ext) ? pos_ext : last_ext;
        fill_count_next = fill_count - CW'(1);
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_v;
    logic [VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cells[i+1];
    end
    iirl_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .ins_value (req.value),
      .left      (left_v),
      .right     (right_v),
      .value     (cells[i]),
      .tap       (taps[i])
    );
  end

  iirl_or_tree #(.N(DEPTH)) u_tree (
    .clk    (clk),
    .taps   (taps),
    .result (tree_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      busy       <= 1'b0;
      pipe       <= '0;
      out_valid  <= 1'b0;
    end else begin
      pipe <= {pipe[TREE_LV-1:0], accept};
      if (accept) begin
        busy       <= 1'b1;
        fill_count <= fill_count_next;
        status_q   <= status_next;
        count_q    <= fill_count_next;
      end
      if (pipe[TREE_LV]) begin
        out_valid <= 1'b1;
        removed_q <= tree_out;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
        busy      <= 1'b0;
      end
    end
  end

  assign req.ready         = !busy;
  assign rsp.valid         = out_valid;
  assign rsp.status        = status_q;
  assign rsp.entry_count   = CNT_W'(count_q);
  assign rsp.removed_value = removed_q;

endmodule

[rtl/core/iirl_cell.sv]
// ----------------------------------------------------------------------------
// iirl_cell
// One list entry: shifts right on insert, left on remove, taps on remove hit.
// ----------------------------------------------------------------------------
module iirl_cell import iirl_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [VAL_W-1:0] ins_value,
  input  logic [VAL_W-1:0] left,
  input  logic [VAL_W-1:0] right,
  output logic [VAL_W-1:0] value,
  output logic [VAL_W-1:0] tap
);

  localparam logic [AT_W-1:0] MY_IDX = AT_W'(IDX);

  logic [VAL_W-1:0] entry;
  logic             hit;
  logic             above;

  assign hit   = (ctrl.at == MY_IDX);
  assign above = (MY_IDX > ctrl.at);
  assign value = entry;
  assign tap   = (ctrl.rem && hit) ? entry : '0;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (hit) begin
        entry <= ins_value;
      end else if (above) begin
        entry <= left;
      end
    end else if (ctrl.rem) begin
      if (hit || above) begin
        entry <= right;
      end
    end
  end

endmodule

[rtl/core/iirl_or_tree.sv]
// ----------------------------------------------------------------------------
// iirl_or_tree
// Registered radix-4 OR tree collecting the one nonzero cell tap.
// ----------------------------------------------------------------------------
module iirl_or_tree import iirl_pkg::*; #(
  parameter int unsigned N = 64
) (
  input  logic             clk,
  input  logic [VAL_W-1:0] taps [N],
  output logic [VAL_W-1:0] result
);

  localparam int unsigned LEVELS = ($clog2(N) + 1) / 2;
  localparam int unsigned PAD    = 4 ** LEVELS;

  logic [VAL_W-1:0] lvl [LEVELS+1][PAD];

  for (genvar i = 0; i < PAD; i++) begin : g_leaf
    if (i < N) begin : g_used
      always_ff @(posedge clk) begin
        lvl[0][i] <= taps[i];
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        lvl[0][i] <= '0;
      end
    end
  end

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    for (genvar j = 0; j < (PAD >> (2 * l)); j++) begin : g_node
      always_ff @(posedge clk) begin
        lvl[l][j] <= lvl[l-1][4*j] | lvl[l-1][4*j+1] | lvl[l-1][4*j+2] | lvl[l-1][4*j+3];
      end
    end
  end

  assign result = lvl[LEVELS][0];

endmodule

[rtl/core/iirl_checker.sv]
// ----------------------------------------------------------------------------
// iirl_checker
// Port-level checks for the indexed insert/remove list, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iirl_checker import iirl_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic [6:0]  rsp_entry_count,
  input logic [31:0] rsp_removed_value
);

  `CHK_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_removed_value), "result word changed while stalled")

  `CHK_NXT(a_one_in_flight, req_valid && req_ready, !req_ready, "second request taken while busy")

  `CHK_IMP(a_ready_no_result, req_ready, !rsp_valid, "request port open with result pending")

  `CHK_IMP(a_count_bound, rsp_valid, rsp_entry_count <= 7'(DEPTH), "entry count above depth")

  `CHK_IMP(a_fail_zero, rsp_valid && rsp_status != ST_DONE, rsp_removed_value == '0, "failed request returned a word")

endmodule

bind indexed_insert_remove_list iirl_checker #(.DEPTH(DEPTH)) u_iirl_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_entry_count   (rsp.entry_count),
  .rsp_removed_value (rsp.removed_value)
);

[tb/indexed_insert_remove_list_tb.sv]
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_tb
// Self-checking bench for the indexed insert/remove list. A directed warm-up
// covers empty, clamped, negative-position and extreme-value requests. Grow,
// shrink and mixed random phases then run the list through full and empty.
// A queue-based shadow list predicts every result at request acceptance. The
// bench checks each result word field by field, in order. Both sides insert
// random gaps and stalls.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_tb import iirl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_DEPTH   = 64;
  localparam int unsigned NUM_RANDOM   = 1100;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned MAX_REPORTS  = 60;

  typedef struct {
    opcode_t     op;
    logic [7:0]  pos;
    logic [31:0] val;
    bit          wait_idle;
  } list_request_t;

  typedef struct {
    status_t     status;
    logic [6:0]  count;
    logic [31:0] removed;
  } list_result_t;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} phase_t;

  logic clk;
  logic rst;

  iirl_req_if req_ch ();
  iirl_rsp_if rsp_ch ();

  indexed_insert_remove_list #(.DEPTH(LIST_DEPTH)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  list_request_t pending_requests[$];
  list_result_t  expected_results[$];
  logic [31:0]   shadow_list[$];

  int unsigned cycle_cnt;
  int unsigned fail_cnt;
  bit          calm;
  int unsigned send_gap;
  int unsigned take_stall;

  // shadow of the list: apply one accepted request, queue its result
  function automatic void apply_request(opcode_t op, logic [7:0] pos, logic [31:0] val);
    list_result_t res;
    int unsigned  at;
    int unsigned  last;
    res.status  = ST_DONE;
    res.removed = '0;
    if (pos[7]) begin
      res.status = ST_NEGATIVE;
    end else if (op == OP_INSERT) begin
      if (shadow_list.size() >= LIST_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        at = (pos < shadow_list.size()) ? pos : shadow_list.size();
        shadow_list.insert(at, val);
      end
    end else begin
      if (shadow_list.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        last        = shadow_list.size() - 1;
        at          = (pos < last) ? pos : last;
        res.removed = shadow_list[at];
        shadow_list.delete(at);
      end
    end
    res.count = 7'(shadow_list.size());
    expected_results.push_back(res);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return $urandom_range(0, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(9, 40);
  endfunction

  function automatic logic [7:0] pick_position();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 8'($urandom_range(0, 70));
    if (r < 75) return 8'($urandom_range(0, 3));
    if (r < 85) return 8'($urandom_range(64, 127));
    if (r < 90) return 8'($urandom_range(128, 255));
    return 8'($urandom);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_request(opcode_t op, logic [7:0] pos, logic [31:0] val,
                                      bit wait_idle);
    list_request_t w;
    w.op        = op;
    w.pos       = pos;
    w.val       = val;
    w.wait_idle = wait_idle;
    pending_requests.push_back(w);
  endfunction

  function automatic void report_mismatch(string field, longint unsigned want,
                                          longint unsigned got);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle count, calm stretches, timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 256 == 0)
      calm <= ($urandom_range(0, 3) == 0);
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin : drive_req
    list_request_t w;
    bit            fire;
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap     <= 0;
    end else begin
      fire = req_ch.valid && req_ch.ready;
      if (fire)
        apply_request(opcode_t'(req_ch.opcode), req_ch.position, req_ch.value);
      if (!req_ch.valid || fire) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_requests.size() != 0 &&
                     !(pending_requests[0].wait_idle && expected_results.size() != 0)) begin
          w = pending_requests.pop_front();
          req_ch.opcode   <= w.op;
          req_ch.position <= w.pos;
          req_ch.value    <= w.val;
          req_ch.valid    <= 1'b1;
          send_gap        <= pick_gap();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin : take_rsp
    list_result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      take_stall   <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result word, expected none, actual status %0d count %0d removed %0h",
                   $time, rsp_ch.status, rsp_ch.entry_count, rsp_ch.removed_value);
        end else begin
          want = expected_results.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch("status", want.status, rsp_ch.status);
          if (rsp_ch.entry_count !== want.count)
            report_mismatch("entry_count", want.count, rsp_ch.entry_count);
          if (rsp_ch.removed_value !== want.removed)
            report_mismatch("removed_value", want.removed, rsp_ch.removed_value);
        end
      end
      if (take_stall != 0) begin
        take_stall   <= take_stall - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        take_stall   <= pick_gap();
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned phase_len;
    int unsigned ins_pct;
    phase_t      ph;

    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.opcode   = 1'b0;
    req_ch.position = '0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
    cycle_cnt       = 0;
    fail_cnt        = 0;
    calm            = 1'b0;

    // directed warm-up
    add_request(OP_REMOVE, 8'd0,   32'h0,         1'b0);  // empty list
    add_request(OP_REMOVE, 8'd127, 32'h5A5A_5A5A, 1'b0);
    add_request(OP_INSERT, 8'hFF,  32'h1111_1111, 1'b0);  // negative
    add_request(OP_REMOVE, 8'h80,  32'h0,         1'b0);
    add_request(OP_INSERT, 8'd127, 32'h7FFF_FFFF, 1'b0);  // into empty
    add_request(OP_INSERT, 8'd0,   32'h8000_0000, 1'b0);  // head
    add_request(OP_INSERT, 8'd1,   32'h0000_0000, 1'b0);  // middle
    add_request(OP_INSERT, 8'd3,   32'hFFFF_FFFF, 1'b0);  // at count
    add_request(OP_INSERT, 8'd100, 32'h1234_5678, 1'b0);  // past end
    add_request(OP_INSERT, 8'h80,  32'hDEAD_BEEF, 1'b0);
    add_request(OP_REMOVE, 8'hFF,  32'h0,         1'b0);
    add_request(OP_REMOVE, 8'd127, 32'h0,         1'b0);  // clamps to last
    add_request(OP_REMOVE, 8'd1,   32'hFFFF_FFFF, 1'b0);
    add_request(OP_REMOVE, 8'd0,   32'h0,         1'b0);
    add_request(OP_REMOVE, 8'd2,   32'h0,         1'b0);
    add_request(OP_REMOVE, 8'd0,   32'h0,         1'b0);
    add_request(OP_REMOVE, 8'd0,   32'h0,         1'b0);

    // random phases; grow phases run the list into full, shrink into empty
    n  = 0;
    ph = PH_GROW;
    while (n < NUM_RANDOM) begin
      phase_len = $urandom_range(80, 160);
      case (ph)
        PH_GROW:   ins_pct = 90;
        PH_SHRINK: ins_pct = 10;
        default:   ins_pct = 50;
      endcase
      for (int unsigned i = 0; i < phase_len && n < NUM_RANDOM; i++) begin
        add_request(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE,
                    pick_position(), pick_value(),
                    (n == 0) || ($urandom_range(0, 99) == 0));
        n++;
      end
      case ($urandom_range(0, 2))
        0:       ph = PH_GROW;
        1:       ph = PH_SHRINK;
        default: ph = PH_MIXED;
      endcase
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || req_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/iirl_pkg.sv
rtl/core/iirl_if.sv
rtl/core/iirl_cell.sv
rtl/core/iirl_or_tree.sv
rtl/core/indexed_insert_remove_list.sv
rtl/core/iirl_checker.sv
tb/indexed_insert_remove_list_tb.sv
